// ===== rtl/ffid_pkg.sv =====
package ffid_pkg;

	// Map geometry: the bitmap is stored as rows of 64 used bits
	localparam int NUM_IDS   = 4096;
	localparam int ID_W      = 12;
	localparam int ROW_BITS  = 64;
	localparam int BIT_W     = 6;
	localparam int NUM_ROWS  = (NUM_IDS + ROW_BITS - 1) / ROW_BITS;
	localparam int ROW_W     = (NUM_ROWS > 1) ? $clog2(NUM_ROWS) : 1;
	localparam int TOP_ID    = NUM_IDS - 1;

	// Configuration port
	localparam int CFG_IDX_W = 2;
	localparam int CFG_W     = 12;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_ID = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_MAX_ID = CFG_IDX_W'(1);
	localparam logic [ID_W-1:0] MIN_ID_RST = ID_W'(300);
	localparam logic [ID_W-1:0] MAX_ID_RST = ID_W'(4095);

	// Request kinds
	localparam logic OP_ALLOC   = 1'b0;
	localparam logic OP_RELEASE = 1'b1;

	typedef struct packed {
		logic            op;
		logic [ID_W-1:0] release_id;
	} req_t;

	typedef struct packed {
		logic            granted;
		logic [ID_W-1:0] given_id;
	} rsp_t;

endpackage

// ===== rtl/first_free_id_bitmap_allocator_top.sv =====
// Allocate: accept, READ, then CHECK once per 64-id row scanned (1 to 64 rows), then DONE;
// the scan reads one bitmap row per cycle from a memory with separate read and write addresses.
// Empty range: accept goes straight to DONE, which loads the result register. A stalled result holds.
// Release: read-modify-write of one row (READ, then REL_WRITE), no result; an out-of-range release is ignored.
// One transaction is processed at a time; the next is accepted once the sequencer is idle.
// Reset clears state, result register and per-row valid bits at once; no clearing pass.
module first_free_id_bitmap_allocator_top
	import ffid_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_stall,
	input  req_t                 req,
	output logic                 rsp_valid,
	input  logic                 rsp_stall,
	output rsp_t                 rsp,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_READ,
		S_CHECK,
		S_REL_WRITE,
		S_DONE
	} state_t;

	state_t                state_q;
	logic [ID_W-1:0]       min_id_q;
	logic [ID_W-1:0]       max_id_q;
	logic [ROW_W-1:0]      row_q;
	logic                  op_q;
	logic [BIT_W-1:0]      rel_bit_q;
	logic                  granted_q;
	logic [ID_W-1:0]       found_id_q;
	logic                  rsp_valid_q;
	rsp_t                  rsp_q;
	logic [NUM_ROWS-1:0]   row_valid_q;

	logic [ROW_BITS-1:0]   mem [NUM_ROWS];
	logic [ROW_BITS-1:0]   rd_data_q;
	logic [ROW_W-1:0]      rd_addr;
	logic                  mem_we;
	logic [ROW_BITS-1:0]   wr_data;

	logic [ID_W-1:0]       top_id;
	logic [ROW_W-1:0]      min_row;
	logic [ROW_W-1:0]      top_row;
	logic                  range_empty;
	logic [ROW_BITS-1:0]   cur_row;
	logic [ROW_BITS-1:0]   cand;
	logic                  hit;
	logic [BIT_W-1:0]      hit_bit;
	logic                  rel_ok;
	logic                  req_acc;
	logic                  rsp_free;

	// Clamp the search to the ids that exist
	always_comb begin
		if (32'(max_id_q) > TOP_ID) begin
			top_id = ID_W'(TOP_ID);
		end else begin
			top_id = max_id_q;
		end
		min_row     = ROW_W'(min_id_q >> BIT_W);
		top_row     = ROW_W'(top_id >> BIT_W);
		range_empty = (min_id_q > top_id);
		rel_ok      = (req.release_id >= min_id_q) && (req.release_id <= max_id_q) &&
		              (32'(req.release_id) <= TOP_ID);
	end

	// Current row as stored; a never-written row reads as all free
	assign cur_row = row_valid_q[row_q] ? rd_data_q : '0;

	// Free ids of the current row that lie inside the search range
	always_comb begin
		for (int b = 0; b < ROW_BITS; b++) begin
			cand[b] = !cur_row[b];
			if ((row_q == min_row) && (BIT_W'(b) < min_id_q[BIT_W-1:0])) begin
				cand[b] = 1'b0;
			end
			if ((row_q == top_row) && (BIT_W'(b) > top_id[BIT_W-1:0])) begin
				cand[b] = 1'b0;
			end
		end
	end

	// Lowest candidate bit
	always_comb begin
		hit     = |cand;
		hit_bit = '0;
		for (int b = ROW_BITS - 1; b >= 0; b--) begin
			if (cand[b]) begin
				hit_bit = BIT_W'(b);
			end
		end
	end

	// Memory address and write data
	always_comb begin
		rd_addr = row_q;
		mem_we  = 1'b0;
		wr_data = cur_row;
		case (state_q)
			S_CHECK: begin
				rd_addr = row_q + ROW_W'(1);
				if (hit) begin
					mem_we           = 1'b1;
					wr_data[hit_bit] = 1'b1;
				end
			end
			S_REL_WRITE: begin
				mem_we             = 1'b1;
				wr_data[rel_bit_q] = 1'b0;
			end
			default: begin
				rd_addr = row_q;
			end
		endcase
	end

	// Bitmap storage
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[row_q] <= wr_data;
		end
		rd_data_q <= mem[rd_addr];
	end

	assign req_stall = (state_q != S_IDLE);
	assign req_acc   = req_valid && !req_stall;
	assign rsp_free  = !rsp_valid_q || !rsp_stall;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// Sequencer, configuration registers and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			min_id_q    <= MIN_ID_RST;
			max_id_q    <= MAX_ID_RST;
			row_valid_q <= '0;
			rsp_valid_q <= 1'b0;
			row_q       <= '0;
			op_q        <= OP_ALLOC;
			rel_bit_q   <= '0;
			granted_q   <= 1'b0;
			found_id_q  <= '0;
			rsp_q       <= '0;
		end else begin
			// Configuration writes; unknown indexes are dropped
			if (cfg_we) begin
				case (cfg_index)
					REG_MIN_ID: min_id_q <= cfg_data[ID_W-1:0];
					REG_MAX_ID: max_id_q <= cfg_data[ID_W-1:0];
					default: ;
				endcase
			end

			// Drop the result once it is taken, unless a new one loads
			if (rsp_valid_q && !rsp_stall && (state_q != S_DONE)) begin
				rsp_valid_q <= 1'b0;
			end

			if (mem_we) begin
				row_valid_q[row_q] <= 1'b1;
			end

			case (state_q)
				S_IDLE: begin
					if (req_acc) begin
						op_q <= req.op;
						if (req.op == OP_RELEASE) begin
							row_q     <= ROW_W'(req.release_id >> BIT_W);
							rel_bit_q <= req.release_id[BIT_W-1:0];
							if (rel_ok) begin
								state_q <= S_READ;
							end
						end else if (range_empty) begin
							granted_q  <= 1'b0;
							found_id_q <= '0;
							state_q    <= S_DONE;
						end else begin
							row_q   <= min_row;
							state_q <= S_READ;
						end
					end
				end
				S_READ: begin
					if (op_q == OP_RELEASE) begin
						state_q <= S_REL_WRITE;
					end else begin
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					// Grant on a hit, give up at the last row, else advance
					if (hit) begin
						granted_q  <= 1'b1;
						found_id_q <= ID_W'({row_q, hit_bit});
						state_q    <= S_DONE;
					end else if (row_q == top_row) begin
						granted_q  <= 1'b0;
						found_id_q <= '0;
						state_q    <= S_DONE;
					end else begin
						row_q <= row_q + ROW_W'(1);
					end
				end
				S_REL_WRITE: begin
					state_q <= S_IDLE;
				end
				S_DONE: begin
					// Hold until the result register is free
					if (rsp_free) begin
						rsp_q.granted  <= granted_q;
						rsp_q.given_id <= found_id_q;
						rsp_valid_q    <= 1'b1;
						state_q        <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== sim/first_free_id_bitmap_allocator_top_tb.sv =====
module first_free_id_bitmap_allocator_top_tb;
	import ffid_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int RANDOM_ITEMS   = 1350;
	localparam int MAX_WAIT       = 11;
	localparam int IDLE_SETTLE    = 10;
	localparam int END_SETTLE     = 80;
	localparam int WATCHDOG_LIMIT = 2000;

	// Indexes past the register list: writes there must change nothing
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = CFG_IDX_W'(3);

	typedef enum logic {ROW_REQ, ROW_CFG} row_kind_e;

	// One directed step: a request or a register write; arg is release id or write data
	typedef struct packed {
		row_kind_e            kind;
		logic                 op;
		logic [ID_W-1:0]      arg;
		logic [CFG_IDX_W-1:0] reg_idx;
		logic                 typed;
		logic                 granted;
		logic [ID_W-1:0]      given;
	} dir_row_t;

	localparam dir_row_t DIRECTED [0:32] = '{
		'{ROW_REQ, OP_ALLOC,   12'd0,    REG_MIN_ID,  1'b1, 1'b1, 12'd300},
		'{ROW_REQ, OP_ALLOC,   12'd0,    REG_MIN_ID,  1'b1, 1'b1, 12'd301},
		'{ROW_REQ, OP_RELEASE, 12'd300,  REG_MIN_ID,  1'b0, 1'b0, 12'd0},
		'{ROW_REQ, OP_ALLOC,   12'd0,    REG_MIN_ID,  1'b1, 1'b1, 12'd300},
		// below the range: ignored
		'{ROW_REQ, OP_RELEASE, 12'd299,  REG_MIN_ID,  1'b0, 1'b0, 12'd0},
		// release of an id that is already free
		'{ROW_REQ, OP_RELEASE, 12'd4095, REG_MIN_ID,  1'b0, 1'b0, 12'd0},
		'{ROW_CFG, OP_ALLOC,   12'd4094, REG_MIN_ID,  1'b0, 1'b0, 12'd0},
		'{ROW_CFG, OP_ALLOC,   12'd4095, REG_MAX_ID,  1'b0, 1'b0, 12'd0},
		'{ROW_REQ, OP_ALLOC,   12'd0,    REG_MIN_ID,  1'b1, 1'b1, 12'd4094},
		'{ROW_REQ, OP_ALLOC,   12'd0,    REG_MIN_ID,  1'b1, 1'b1, 12'd4095},
		// range exhausted
		'{ROW_REQ, OP_ALLOC,   12'd0,    REG_MIN_ID,  1'b1, 1'b0, 12'd0},
		'{ROW_REQ, OP_RELEASE, 12'd4095, REG_MIN_ID,  1'b0, 1'b0, 12'd0},
		'{ROW_REQ, OP_ALLOC,   12'd0,    REG_MIN_ID,  1'b1, 1'b1, 12'd4095},
		'{ROW_CFG, OP_ALLOC,   12'd0,    REG_MIN_ID,  1'b0, 1'b0, 12'd0},
		'{ROW_CFG, OP_ALLOC,   12'd0,    REG_MAX_ID,  1'b0, 1'b0, 12'd0},
		'{ROW_REQ, OP_ALLOC,   12'd0,    REG_MIN_ID,  1'b1, 1'b1, 12'd0},
		'{ROW_REQ, OP_ALLOC,   12'd0,    REG_MIN_ID,  1'b1, 1'b0, 12'd0},
		// held id, but outside the new bounds: stays held
		'{ROW_REQ, OP_RELEASE, 12'd300,  REG_MIN_ID,  1'b0, 1'b0, 12'd0},
		'{ROW_CFG, OP_ALLOC,   12'd4095, REG_SPARE_A, 1'b0, 1'b0, 12'd0},
		'{ROW_CFG, OP_ALLOC,   12'd4095, REG_SPARE_B, 1'b0, 1'b0, 12'd0},
		'{ROW_REQ, OP_ALLOC,   12'd0,    REG_MIN_ID,  1'b1, 1'b0, 12'd0},
		// empty range: min above max
		'{ROW_CFG, OP_ALLOC,   12'd5,    REG_MIN_ID,  1'b0, 1'b0, 12'd0},
		'{ROW_CFG, OP_ALLOC,   12'd3,    REG_MAX_ID,  1'b0, 1'b0, 12'd0},
		'{ROW_REQ, OP_ALLOC,   12'd0,    REG_MIN_ID,  1'b1, 1'b0, 12'd0},
		'{ROW_REQ, OP_RELEASE, 12'd4,    REG_MIN_ID,  1'b0, 1'b0, 12'd0},
		'{ROW_CFG, OP_ALLOC,   12'd0,    REG_MIN_ID,  1'b0, 1'b0, 12'd0},
		'{ROW_CFG, OP_ALLOC,   12'd4095, REG_MAX_ID,  1'b0, 1'b0, 12'd0},
		'{ROW_REQ, OP_ALLOC,   12'd4095, REG_MIN_ID,  1'b1, 1'b1, 12'd1},
		'{ROW_REQ, OP_RELEASE, 12'd0,    REG_MIN_ID,  1'b0, 1'b0, 12'd0},
		'{ROW_REQ, OP_ALLOC,   12'd4095, REG_MIN_ID,  1'b1, 1'b1, 12'd0},
		'{ROW_REQ, OP_RELEASE, 12'd4095, REG_MIN_ID,  1'b0, 1'b0, 12'd0},
		'{ROW_REQ, OP_RELEASE, 12'd300,  REG_MIN_ID,  1'b0, 1'b0, 12'd0},
		'{ROW_REQ, OP_ALLOC,   12'd2730, REG_MIN_ID,  1'b0, 1'b0, 12'd0}
	};

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 req_valid = 1'b0;
	logic                 req_stall;
	req_t                 req       = '0;
	logic                 rsp_valid;
	logic                 rsp_stall = 1'b0;
	rsp_t                 rsp;
	logic                 cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_data  = '0;

	// Mirror of the allocator: used bits and current bounds
	bit              id_used [NUM_IDS];
	logic [ID_W-1:0] lo_bound = MIN_ID_RST;
	logic [ID_W-1:0] hi_bound = MAX_ID_RST;

	rsp_t pending_grants [$];
	int   mismatch_count = 0;
	int   idle_cycles    = 0;
	int   rsp_hold_left  = 0;
	bit   send_burst     = 1'b0;
	bit   recv_burst     = 1'b0;

	first_free_id_bitmap_allocator_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	task automatic log_mismatch(input string msg);
		$display("[%0t] MISMATCH: %s", $time, msg);
		mismatch_count++;
	endtask

	// Apply one request to the mirror; a grant or a refusal comes back on allocate only
	function automatic void grant_or_free(input req_t r, output bit yields, output rsp_t g);
		int top;
		int rid;
		rid    = int'(r.release_id);
		yields = 1'b0;
		g      = '0;
		if (r.op == OP_RELEASE) begin
			if (rid >= int'(lo_bound) && rid <= int'(hi_bound) && rid < NUM_IDS)
				id_used[rid] = 1'b0;
			return;
		end
		yields = 1'b1;
		top = (int'(hi_bound) > TOP_ID) ? TOP_ID : int'(hi_bound);
		for (int i = int'(lo_bound); i <= top; i++) begin
			if (!id_used[i]) begin
				id_used[i] = 1'b1;
				g.granted  = 1'b1;
				g.given_id = ID_W'(i);
				return;
			end
		end
	endfunction

	// Present one transaction and record its expected result at acceptance
	task automatic send_req(input req_t r, input bit typed, input rsp_t want);
		int   gap;
		bit   yields;
		rsp_t g;
		gap = send_burst ? 0 : $urandom_range(0, MAX_WAIT);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req       <= r;
		req_valid <= 1'b1;
		do
			@(posedge clk);
		while (req_stall);
		grant_or_free(r, yields, g);
		if (yields)
			pending_grants.push_back(typed ? want : g);
		@(negedge clk);
	endtask

	// Hold off until every grant has come back and a trailing release has finished
	task automatic drain_idle();
		req_valid <= 1'b0;
		while (pending_grants.size() != 0)
			@(negedge clk);
		repeat (IDLE_SETTLE) @(negedge clk);
	endtask

	task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		if (idx == REG_MIN_ID)
			lo_bound = val;
		else if (idx == REG_MAX_ID)
			hi_bound = val;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	// Result stall: draw a fresh wait after each accepted result
	always @(negedge clk) begin
		if (rsp_hold_left > 0) begin
			rsp_stall <= 1'b1;
			rsp_hold_left--;
		end else begin
			rsp_stall <= 1'b0;
		end
	end

	// Check results against the oldest expectation; watch for a hang
	always @(posedge clk) begin
		rsp_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (pending_grants.size() == 0) begin
				log_mismatch($sformatf("result with nothing pending: granted=%0b id=%0d",
					rsp.granted, rsp.given_id));
			end else begin
				want = pending_grants.pop_front();
				if (rsp.granted !== want.granted)
					log_mismatch($sformatf("granted %0b, want %0b", rsp.granted, want.granted));
				if (rsp.given_id !== want.given_id)
					log_mismatch($sformatf("given_id %0d, want %0d",
						rsp.given_id, want.given_id));
			end
			rsp_hold_left = recv_burst ? 0 : $urandom_range(0, MAX_WAIT);
		end
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || cfg_we)
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("** first_free_id_bitmap_allocator_top: FAILED **");
			$finish;
		end
	end

	initial begin
		int   counted;
		int   phase_len;
		int   lo_pick;
		int   hi_pick;
		int   pick;
		int   cand [$];
		req_t r;
		rsp_t want;

		counted = 0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed steps: register writes only once the block is idle
		foreach (DIRECTED[i]) begin
			if (DIRECTED[i].kind == ROW_CFG) begin
				if (i == 0 || DIRECTED[i-1].kind != ROW_CFG)
					drain_idle();
				write_cfg(DIRECTED[i].reg_idx, DIRECTED[i].arg);
			end else begin
				r.op          = DIRECTED[i].op;
				r.release_id  = DIRECTED[i].arg;
				want.granted  = DIRECTED[i].granted;
				want.given_id = DIRECTED[i].given;
				send_req(r, DIRECTED[i].typed, want);
			end
		end

		// Random phases, each with fresh bounds and its own idling style
		while (counted < RANDOM_ITEMS) begin
			pick = $urandom_range(0, 9);
			if (pick <= 3) begin
				lo_pick = $urandom_range(0, TOP_ID);
				hi_pick = lo_pick + $urandom_range(0, 150);
				if (hi_pick > TOP_ID)
					hi_pick = TOP_ID;
			end else if (pick <= 5) begin
				lo_pick = $urandom_range(0, 700);
				hi_pick = $urandom_range(3400, TOP_ID);
			end else if (pick == 6) begin
				lo_pick = 0;
				hi_pick = TOP_ID;
			end else if (pick == 7) begin
				lo_pick = $urandom_range(1, TOP_ID);
				hi_pick = $urandom_range(0, lo_pick - 1);
			end else begin
				lo_pick = $urandom_range(3900, TOP_ID);
				hi_pick = TOP_ID;
			end
			drain_idle();
			write_cfg(REG_MIN_ID, CFG_W'(lo_pick));
			write_cfg(REG_MAX_ID, CFG_W'(hi_pick));
			send_burst = ($urandom_range(0, 3) == 0);
			recv_burst = ($urandom_range(0, 3) == 0);
			phase_len  = (pick == 7) ? $urandom_range(5, 20) : $urandom_range(40, 140);

			for (int k = 0; k < phase_len && counted < RANDOM_ITEMS; k++) begin
				pick         = $urandom_range(0, 99);
				r.release_id = ID_W'($urandom_range(0, TOP_ID));
				if (pick < 50) begin
					r.op = OP_ALLOC;
				end else if (pick < 85) begin
					// free an id that is held inside the current bounds, if there is one
					r.op = OP_RELEASE;
					cand.delete();
					for (int i = int'(lo_bound); i <= int'(hi_bound); i++)
						if (id_used[i])
							cand.push_back(i);
					if (cand.size() != 0)
						r.release_id = ID_W'(cand[$urandom_range(0, cand.size() - 1)]);
				end else begin
					r.op = OP_RELEASE;
				end
				if ($urandom_range(0, 49) == 0)
					drain_idle();
				send_req(r, 1'b0, '0);
				counted++;
			end
		end

		req_valid <= 1'b0;
		while (pending_grants.size() != 0)
			@(posedge clk);
		repeat (END_SETTLE) @(posedge clk);
		if (mismatch_count == 0 && pending_grants.size() == 0)
			$display("** first_free_id_bitmap_allocator_top: PASSED **");
		else
			$display("** first_free_id_bitmap_allocator_top: FAILED **");
		$finish;
	end

endmodule
